@@ sv/gdad_pkg.sv @@
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, constants and helper functions for the date adder.
// ----------------------------------------------------------------------------
package gdad_pkg;

  // Day count width and derived datapath widths
  localparam int DAYS_BITS  = 16;
  localparam int DAY_W      = DAYS_BITS + 1;  // start day plus count, no overflow
  localparam int YEAR_W     = 14;
  localparam int YEAR_MAX   = 16383;

  // Gregorian cycle used for the century rules
  localparam int YEAR_CYCLE = 400;
  localparam int CENTURY    = 100;

  // Reduction of the start year mod 400 by shifted subtraction: 400<<5 .. 400<<0
  localparam int REDUCE_LAST = 5;
  localparam int STEP_W      = 3;

  // Month numbers
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } gdad_status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_WALK,
    S_RESULT
  } gdad_state_t;

  // Input transaction
  typedef struct packed {
    logic [5:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [15:0] add_days;
  } gdad_in_t;

  // Result transaction
  typedef struct packed {
    logic [4:0]   result_day;
    logic [3:0]   result_month;
    logic [13:0]  result_year;
    gdad_status_t status;
  } gdad_out_t;

  // Flags and difference from the shared subtract/compare unit
  typedef struct packed {
    logic [DAY_W-1:0] diff;
    logic             lt;
    logic             eq;
  } gdad_alu_t;

  // Length of month m; leap selects 29 days for February
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      MONTH_FEB:                                 len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ sv/gdad_alu.sv @@
// ----------------------------------------------------------------------------
// gdad_alu
// Shared subtract/compare unit: a - b with less-than and equal flags.
// ----------------------------------------------------------------------------
module gdad_alu (
  input  logic [gdad_pkg::DAY_W-1:0] a,
  input  logic [gdad_pkg::DAY_W-1:0] b,
  output gdad_pkg::gdad_alu_t        res
);

  logic [gdad_pkg::DAY_W:0] wide;

  // One wide subtract; the borrow bit gives a < b
  always_comb begin
    wide     = {1'b0, a} - {1'b0, b};
    res.diff = wide[gdad_pkg::DAY_W-1:0];
    res.lt   = wide[gdad_pkg::DAY_W];
    res.eq   = (a == b);
  end

endmodule

@@ sv/gregorian_date_add_days_unit.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_add_days_unit
// Adds a day count to a Gregorian date by walking one month per cycle.
// ----------------------------------------------------------------------------
// Sequence: an invalid date gives its result in the cycle after start.
//   A valid date first reduces the year mod 400 in S_REDUCE, then steps
//   through the months in S_WALK, then shows its result in S_RESULT.
// Throughput: one transaction at a time; busy stays high until done has shown.
// The shared subtract/compare unit sets the pace: one month per cycle.
// Reset (rst, synchronous) returns the sequencer to idle; the receiver cannot stall.
module gregorian_date_add_days_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  gdad_pkg::gdad_in_t   request,
  output logic                 busy,
  output logic                 done,
  output gdad_pkg::gdad_out_t  result
);

  gdad_pkg::gdad_state_t state, state_next;

  logic [gdad_pkg::DAY_W-1:0]  day;
  logic [3:0]                  month;
  logic [gdad_pkg::YEAR_W-1:0] year;
  logic [gdad_pkg::YEAR_W-1:0] ymod;   // year mod 400 once reduced
  logic [gdad_pkg::STEP_W-1:0] step;
  gdad_pkg::gdad_out_t         res;

  logic [gdad_pkg::DAY_W-1:0]  alu_a, alu_b;
  gdad_pkg::gdad_alu_t         alu;

  logic                        in_valid;
  logic                        leap;
  logic [4:0]                  mlen;
  logic                        fits;
  logic                        ovf;
  logic                        accept;

  // Input date check
  assign in_valid = (request.start_day != 6'd0) && (request.start_day <= 6'd31) &&
                    (request.start_month >= gdad_pkg::MONTH_JAN) &&
                    (request.start_month <= gdad_pkg::MONTH_DEC) &&
                    (request.start_year != '0);

  assign accept = start && !busy;

  // Leap rule from year mod 4 and the year's place in the 400-year cycle
  always_comb begin
    leap = ((year[1:0] == 2'b00) &&
            (ymod != gdad_pkg::YEAR_W'(0)) &&
            (ymod != gdad_pkg::YEAR_W'(gdad_pkg::CENTURY)) &&
            (ymod != gdad_pkg::YEAR_W'(2 * gdad_pkg::CENTURY)) &&
            (ymod != gdad_pkg::YEAR_W'(3 * gdad_pkg::CENTURY))) ||
           (ymod == gdad_pkg::YEAR_W'(0));
    mlen = gdad_pkg::month_len(month, leap);
  end

  // Operand select for the shared unit
  always_comb begin
    if (state == gdad_pkg::S_REDUCE) begin
      alu_a = gdad_pkg::DAY_W'(ymod);
      alu_b = gdad_pkg::DAY_W'(gdad_pkg::YEAR_CYCLE) << step;
    end else begin
      alu_a = day;
      alu_b = gdad_pkg::DAY_W'(mlen);
    end
  end

  gdad_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  // Walk decisions
  assign fits = alu.lt || alu.eq;
  assign ovf  = !fits && (month == gdad_pkg::MONTH_DEC) &&
                (year >= gdad_pkg::YEAR_W'(gdad_pkg::YEAR_MAX));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gdad_pkg::S_IDLE: begin
        if (start) state_next = in_valid ? gdad_pkg::S_REDUCE : gdad_pkg::S_RESULT;
      end
      gdad_pkg::S_REDUCE: begin
        if (step == '0) state_next = gdad_pkg::S_WALK;
      end
      gdad_pkg::S_WALK: begin
        if (fits || ovf) state_next = gdad_pkg::S_RESULT;
      end
      gdad_pkg::S_RESULT: begin
        state_next = gdad_pkg::S_IDLE;
      end
      default: state_next = gdad_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      gdad_pkg::S_IDLE:   busy = 1'b0;
      gdad_pkg::S_RESULT: done = 1'b1;
      default: ;
    endcase
  end

  assign result = res;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdad_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      gdad_pkg::S_IDLE: begin
        if (accept) begin
          day   <= gdad_pkg::DAY_W'(request.start_day) +
                   gdad_pkg::DAY_W'(request.add_days[gdad_pkg::DAYS_BITS-1:0]);
          month <= request.start_month;
          year  <= request.start_year;
          ymod  <= request.start_year;
          step  <= gdad_pkg::STEP_W'(gdad_pkg::REDUCE_LAST);
          res   <= '{result_day: '0, result_month: '0, result_year: '0,
                     status: gdad_pkg::ST_INVALID};
        end
      end
      gdad_pkg::S_REDUCE: begin
        if (!alu.lt) ymod <= alu.diff[gdad_pkg::YEAR_W-1:0];
        step <= step - 1'b1;
      end
      gdad_pkg::S_WALK: begin
        if (fits) begin
          res <= '{result_day: day[4:0], result_month: month, result_year: year,
                   status: gdad_pkg::ST_OK};
        end else if (ovf) begin
          res <= '{result_day: '0, result_month: '0, result_year: '0,
                   status: gdad_pkg::ST_OVERFLOW};
        end else begin
          day <= alu.diff;
          if (month == gdad_pkg::MONTH_DEC) begin
            month <= gdad_pkg::MONTH_JAN;
            year  <= year + 1'b1;
            ymod  <= (ymod == gdad_pkg::YEAR_W'(gdad_pkg::YEAR_CYCLE - 1)) ?
                     '0 : ymod + 1'b1;
          end else begin
            month <= month + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // A result only shows while the unit is busy with it
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // Accepted transaction keeps the unit busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accept did not raise busy");

  // Failed results carry zero date fields
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != gdad_pkg::ST_OK) |->
      (result.result_day == '0 && result.result_month == '0 && result.result_year == '0))
    else $error("nonzero date on failed result");

  // Good results carry an in-range date
  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == gdad_pkg::ST_OK) |->
      (result.result_day != '0 && result.result_month != '0 &&
       result.result_month <= gdad_pkg::MONTH_DEC && result.result_year != '0))
    else $error("out-of-range date on good result");

  // The cycle position stays below 400 during the walk
  a_ymod_range: assert property (@(posedge clk) disable iff (rst)
    (state == gdad_pkg::S_WALK) |-> (ymod < gdad_pkg::YEAR_W'(gdad_pkg::YEAR_CYCLE)))
    else $error("year cycle position out of range");
`endif

endmodule

@@ dv/gdad_checker.sv @@
// ----------------------------------------------------------------------------
// gdad_checker
// Watches the request and result channels of the date adder. Every accepted
// request is run through a date walker to get the expected result, and each
// strobed result is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module gdad_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  gdad_pkg::gdad_in_t  request,
  input  logic                done,
  input  gdad_pkg::gdad_out_t result,
  output int                  fail_count,
  output int                  pending
);

  localparam int unsigned COUNT_MASK = (32'd1 << gdad_pkg::DAYS_BITS) - 1;
  localparam int          REPORT_MAX = 10;

  gdad_pkg::gdad_out_t expected_dates[$];

  // Gregorian leap rule
  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    int unsigned len;
    if (m == gdad_pkg::MONTH_FEB) len = is_leap(y) ? 29 : 28;
    else if (m == gdad_pkg::MONTH_APR || m == gdad_pkg::MONTH_JUN ||
             m == gdad_pkg::MONTH_SEP || m == gdad_pkg::MONTH_NOV)
      len = 30;
    else len = 31;
    return len;
  endfunction

  // Walk forward one month at a time until the day fits its month
  function automatic gdad_pkg::gdad_out_t add_days_to_date(gdad_pkg::gdad_in_t req);
    gdad_pkg::gdad_out_t res;
    int unsigned         d;
    int unsigned         m;
    int unsigned         y;
    int unsigned         len;
    bit                  fits;
    res  = '0;
    d    = req.start_day;
    m    = req.start_month;
    y    = req.start_year;
    fits = 1'b0;
    if (d < 1 || d > 31 || m < gdad_pkg::MONTH_JAN || m > gdad_pkg::MONTH_DEC ||
        y == 0) begin
      res.status = gdad_pkg::ST_INVALID;
      return res;
    end
    d = d + (req.add_days & COUNT_MASK);
    while (!fits) begin
      len = days_in_month(m, y);
      if (d <= len) begin
        fits = 1'b1;
      end else begin
        d = d - len;
        if (m == gdad_pkg::MONTH_DEC) begin
          // rollover past the last representable year
          if (y >= gdad_pkg::YEAR_MAX) begin
            res.status = gdad_pkg::ST_OVERFLOW;
            return res;
          end
          m = gdad_pkg::MONTH_JAN;
          y = y + 1;
        end else begin
          m = m + 1;
        end
      end
    end
    res.result_day   = d[4:0];
    res.result_month = m[3:0];
    res.result_year  = y[13:0];
    res.status       = gdad_pkg::ST_OK;
    return res;
  endfunction

  // Score results first, then record any newly accepted transaction
  always @(posedge clk) begin
    gdad_pkg::gdad_out_t want;
    if (rst) begin
      fail_count = 0;
      pending    = expected_dates.size();
    end else begin
      if (done) begin
        if (expected_dates.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_MAX)
            $display("ERROR: result with nothing pending: day %0d month %0d year %0d status %0d",
                     result.result_day, result.result_month, result.result_year,
                     result.status);
        end else begin
          want = expected_dates.pop_front();
          if (result.result_day !== want.result_day ||
              result.result_month !== want.result_month ||
              result.result_year !== want.result_year ||
              result.status !== want.status) begin
            fail_count = fail_count + 1;
            if (fail_count <= REPORT_MAX)
              $display("ERROR: mismatch exp d/m/y/st %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       want.result_day, want.result_month, want.result_year, want.status,
                       result.result_day, result.result_month, result.result_year,
                       result.status);
          end
        end
      end
      if (start && !busy)
        expected_dates.push_back(add_days_to_date(request));
      pending = expected_dates.size();
    end
  end

endmodule

@@ dv/tb_gregorian_date_add_days_unit.sv @@
// ----------------------------------------------------------------------------
// tb_gregorian_date_add_days_unit
// Drives the date adder with directed edge dates (invalid fields, leap and
// century Februaries, out-of-range days, year overflow, largest counts) and
// then weighted random transactions under three sender idle profiles. The
// checker beside the block predicts and scores every result.
// ----------------------------------------------------------------------------
module tb_gregorian_date_add_days_unit;

  localparam int RANDOM_ITEMS = 250;
  localparam int STALL_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 20;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic                done;
  gdad_pkg::gdad_in_t  request;
  gdad_pkg::gdad_out_t result;
  int                  fail_count;
  int                  pending;
  int                  idle_pct;
  int                  stall_cycles = 0;

  gregorian_date_add_days_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  gdad_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic gdad_pkg::gdad_in_t date_req(int d, int m, int y, int n);
    gdad_pkg::gdad_in_t req;
    req.start_day   = d[5:0];
    req.start_month = m[3:0];
    req.start_year  = y[13:0];
    req.add_days    = n[15:0];
    return req;
  endfunction

  // Mostly well-formed dates with short counts; some noise, overflow bait
  // and full-range counts
  function automatic gdad_pkg::gdad_in_t random_date();
    gdad_pkg::gdad_in_t req;
    int                 pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      req = gdad_pkg::gdad_in_t'({8'($urandom), $urandom});
    end else if (pick < 20) begin
      req = date_req($urandom_range(1, 31), $urandom_range(10, 12),
                     $urandom_range(16370, gdad_pkg::YEAR_MAX), $urandom_range(0, 3000));
    end else if (pick < 25) begin
      req = date_req($urandom_range(1, 31), $urandom_range(1, 12),
                     $urandom_range(1, gdad_pkg::YEAR_MAX), $urandom_range(0, 65535));
    end else begin
      req = date_req($urandom_range(1, 31), $urandom_range(1, 12),
                     $urandom_range(1, gdad_pkg::YEAR_MAX), $urandom_range(0, 800));
    end
    return req;
  endfunction

  // One transaction: random idle cycles, then hold start until accepted
  task automatic send_date(gdad_pkg::gdad_in_t req);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Sender holds off until every expected result is back
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    request  = '0;
    idle_pct = 34;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // invalid fields
    send_date(date_req(0, 1, 2000, 5));
    send_date(date_req(32, 6, 2000, 5));
    send_date(date_req(63, 15, 16383, 65535));
    send_date(date_req(10, 0, 2000, 1));
    send_date(date_req(10, 13, 2000, 1));
    send_date(date_req(10, 5, 0, 1));
    // smallest and largest valid dates, overflow
    send_date(date_req(1, 1, 1, 0));
    send_date(date_req(31, 12, 16383, 0));
    send_date(date_req(31, 12, 16383, 1));
    send_date(date_req(1, 1, 16383, 65535));
    // day past end of month normalizes forward
    send_date(date_req(31, 4, 2023, 0));
    send_date(date_req(30, 2, 2000, 0));
    send_date(date_req(31, 2, 2100, 0));
    // leap rule: century, four-hundred, plain leap, common year
    send_date(date_req(28, 2, 1900, 1));
    send_date(date_req(28, 2, 2000, 1));
    send_date(date_req(28, 2, 2024, 1));
    send_date(date_req(28, 2, 2023, 1));
    // year rollover and largest counts
    send_date(date_req(31, 12, 1999, 1));
    send_date(date_req(1, 1, 2000, 65535));
    send_date(date_req(31, 1, 1, 65535));
    send_date(date_req(15, 6, 9999, 365));
    send_date(date_req(31, 1, 8191, 30));
    drain_results();

    // random traffic under three sender idle profiles
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        drain_results();
        idle_pct = 71;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        drain_results();
        idle_pct = 0;
      end
      send_date(random_date());
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
